[hw/rtl/grm_pkg.sv]
// Package: word types, command codes and luma weights for the gray row mirror.
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

  // Input word command codes
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       row_end;
  } out_word_t;

  // Row width register
  localparam int unsigned   RowWidthBits  = 12;
  localparam logic [11:0]   RowWidthReset = 12'd640;

  // 0.8 fixed-point luma weights (0.21, 0.72, 0.07)
  localparam logic [7:0] WeightRed   = 8'd54;
  localparam logic [7:0] WeightGreen = 8'd184;
  localparam logic [7:0] WeightBlue  = 8'd18;

endpackage

`default_nettype wire

[hw/rtl/grm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module grm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/grm_luma.sv]
// Luma unit: fixed-point weighted sum of red, green and blue.
`timescale 1ns / 1ps
`default_nettype none

module grm_luma (
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output      logic [7:0] gray_o
);

  import grm_pkg::*;

  logic [15:0] prod_r, prod_g, prod_b;
  logic [15:0] sum;

  // constant products; the sum tops out at 255*256 so never overflows
  assign prod_r = {8'd0, red_i}   * {8'd0, WeightRed};
  assign prod_g = {8'd0, green_i} * {8'd0, WeightGreen};
  assign prod_b = {8'd0, blue_i}  * {8'd0, WeightBlue};
  assign sum    = prod_r + prod_g + prod_b;
  assign gray_o = sum[15:8];

endmodule

`default_nettype wire

[hw/rtl/grayscale_row_mirror.sv]
// Top level: RGB to gray conversion with a ping-pong row store that mirrors each row.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | in_word_i  (command, r, g, b)
//   out     | output    | out_valid_o/out_ready_i | out_word_o (gray, row_end)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (row_width)
//
// One input word per clock while input is not stalled. A mirrored value for the
// word that drains it is registered at the row store read, then in the output register.
// The store is a single RAM; a read and a write in the same cycle hit opposite banks.
// Reset clears the counters and the pending flag; the store is not cleared.
// When the output register is full and not taken while the read stage also
// holds a word, the read stage holds and input is stalled.
`timescale 1ns / 1ps
`default_nettype none

module grayscale_row_mirror #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire grm_pkg::in_word_t  in_word_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      grm_pkg::out_word_t out_word_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [11:0]        cfg_data_i
);

  import grm_pkg::*;

  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned Depth    = 2 * MAX_WIDTH;
  localparam int unsigned AddrBits = $clog2(Depth);
  localparam logic [ColBits-1:0] ColMax = ColBits'(MAX_WIDTH - 1);
  localparam logic [ColBits-1:0] ResetLastCol =
    (int'(RowWidthReset) > int'(MAX_WIDTH)) ? ColMax : ColBits'(int'(RowWidthReset) - 1);

  // Row width, kept as the last column index after clamping
  logic [ColBits-1:0] last_col_q, last_col_d;
  logic [31:0]        cfg_wide;

  assign cfg_ready_o = 1'b1;
  assign cfg_wide    = {20'd0, cfg_data_i};

  always_comb begin
    last_col_d = last_col_q;
    if (cfg_valid_i) begin
      if (cfg_wide == 32'd0) begin
        last_col_d = '0;
      end else if (cfg_wide > 32'(MAX_WIDTH)) begin
        last_col_d = ColMax;
      end else begin
        last_col_d = ColBits'(cfg_wide - 32'd1);
      end
    end
  end

  // Fill and drain state
  logic [ColBits-1:0] fill_col_q, fill_col_d;
  logic [ColBits-1:0] drain_col_q, drain_col_d;
  logic               fill_bank_q, fill_bank_d;
  logic               pending_q, pending_d;

  // Read stage and output register
  logic      rd_valid_q, rd_valid_d;
  logic      rd_last_q, rd_last_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      rd_advance;
  logic      accept;

  // Row store ports
  logic                ram_we, ram_re;
  logic [AddrBits-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_rdata;
  logic [7:0]          gray;

  logic [ColBits-1:0] rd_col, wr_col;
  logic               drain_last, fill_last, is_pixel;

  assign rd_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !rd_valid_q || rd_advance;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (in_word_i.command == CMD_PIXEL);

  // column selection, tolerant of a width lowered mid-row
  assign drain_last = (drain_col_q >= last_col_q);
  assign rd_col     = (drain_col_q <= last_col_q) ? (last_col_q - drain_col_q) : '0;
  assign fill_last  = (fill_col_q >= last_col_q);
  assign wr_col     = fill_last ? last_col_q : fill_col_q;

  // Read and write hit opposite banks in the same cycle, so no forwarding is needed
  assign ram_re    = accept && pending_q;
  assign ram_raddr = fill_bank_q ? AddrBits'(rd_col)
                                 : AddrBits'(MAX_WIDTH) + AddrBits'(rd_col);
  assign ram_we    = accept && is_pixel;
  assign ram_waddr = fill_bank_q ? AddrBits'(MAX_WIDTH) + AddrBits'(wr_col)
                                 : AddrBits'(wr_col);

  grm_luma u_luma (
    .red_i   (in_word_i.red),
    .green_i (in_word_i.green),
    .blue_i  (in_word_i.blue),
    .gray_o  (gray)
  );

  grm_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (gray),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Drain first, then fill; a completed row restarts both columns
  always_comb begin
    fill_col_d  = fill_col_q;
    drain_col_d = drain_col_q;
    fill_bank_d = fill_bank_q;
    pending_d   = pending_q;
    if (accept) begin
      if (pending_q) begin
        if (drain_last) begin
          pending_d   = 1'b0;
          drain_col_d = '0;
        end else begin
          drain_col_d = drain_col_q + 1'b1;
        end
      end
      if (is_pixel) begin
        if (fill_last) begin
          fill_bank_d = !fill_bank_q;
          fill_col_d  = '0;
          drain_col_d = '0;
          pending_d   = 1'b1;
        end else begin
          fill_col_d = fill_col_q + 1'b1;
        end
      end
    end
  end

  // Read stage loads whenever it is free; the output register takes it as it moves on
  always_comb begin
    rd_valid_d  = rd_valid_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_ready_o) begin
      rd_valid_d = ram_re;
      rd_last_d  = drain_last;
    end
    if (rd_advance) begin
      out_valid_d = rd_valid_q;
      if (rd_valid_q) begin
        out_d.gray    = ram_rdata;
        out_d.row_end = rd_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q  <= ResetLastCol;
      fill_col_q  <= '0;
      drain_col_q <= '0;
      fill_bank_q <= 1'b0;
      pending_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      last_col_q  <= last_col_d;
      fill_col_q  <= fill_col_d;
      drain_col_q <= drain_col_d;
      fill_bank_q <= fill_bank_d;
      pending_q   <= pending_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_last_q <= rd_last_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
